FILE: hw/rtl/crc24c_pkg.sv
package crc24c_pkg;

    localparam int CRC_W        = 25;
    localparam int CRC_OUT_W    = 24;
    localparam logic [CRC_W-1:0] CRC_GEN  = 25'h1B2B117;
    localparam logic [CRC_W-1:0] CRC_INIT = 25'h1FFFFFF;

    localparam int DIGIT_W      = 4;
    localparam int BURST_W      = 128;
    localparam int WIN_W        = 2 * BURST_W;
    localparam int BURST_DIGITS = BURST_W / DIGIT_W;
    localparam int FLUSH_DIGITS = CRC_OUT_W / DIGIT_W;
    localparam int WIN_DIGITS   = WIN_W / DIGIT_W;
    localparam int SPILL_LIMIT  = BURST_W - CRC_OUT_W;

    // One step of the augmented CRC: shift in one message bit, reduce on bit 24.
    function automatic logic [CRC_W-1:0] crc_bit(input logic [CRC_W-1:0] c, input logic b);
        logic [CRC_W-1:0] t;
        t = {c[CRC_W-2:0], b};
        if (t[CRC_W-1])
        begin
            t = t ^ CRC_GEN;
        end
        return t;
    endfunction

endpackage

FILE: hw/rtl/crc24c_attach_stream_unit.sv
// CRC24C attachment on a stream of 128-bit bursts. A beat with s_tuser 0 is a
// length command (message length in bits, 0 to 255); beats with s_tuser 1 carry
// the ceil(length/128) data bursts. The CRC register (25 bits, all ones, generator
// 0x1B2B117) runs MSB first over exactly the message bits, is flushed with 24 zero
// bits, and the 24-bit CRC is XORed into the bit positions right after the data.
// When fewer than 24 bits are free in the final burst the CRC spills into one
// extra burst; a zero-length command yields an all-zero burst and a CRC burst.
// Non-final bursts pass unchanged with m_tlast 0; the final beat has m_tlast 1.
// Bursts arriving with no open message are dropped. A nonzero length command only
// sets up the message; a zero-length command goes on to the flush, the insert pass
// and two output beats. A data burst is clocked through the CRC four bits a cycle
// from the top of a rotating shift register; a non-final burst is then handed off
// to the output register. The final burst adds the flush and an insert pass that
// rotates a 256-bit window (burst plus spill burst) four bits a cycle and XORs the
// aligned CRC digits in as they pass the top.
// s_tready is high only while the block waits for a beat; the output register
// lets the next beat be accepted while the previous result is still held.
module crc24c_attach_stream_unit
    import crc24c_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,  // msg_length[7:0], data_hi[71:8], data_lo[135:72]
    input  logic [0:0]   s_tuser,  // req_type[0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,  // out_hi[63:0], out_lo[127:64]
    output logic         m_tlast   // out_last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DATA,
        ST_FLUSH,
        ST_INSERT,
        ST_EMIT,
        ST_EMIT_EXT
    } state_t;

    state_t               state_reg, state_next;
    logic [CRC_W-1:0]     crc_reg, crc_next;
    logic [7:0]           msg_bits_reg, msg_bits_next;
    logic [7:0]           rem_reg, rem_next;
    logic [1:0]           bursts_left_reg, bursts_left_next;
    logic                 in_message_reg, in_message_next;
    logic                 final_reg, final_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic [WIN_W-1:0]     win_reg, win_next;
    logic [27:0]          c28_reg, c28_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [127:0]         m_tdata_reg, m_tdata_next;
    logic                 m_tlast_reg, m_tlast_next;

    logic [7:0]           used;
    logic                 spill;
    logic [5:0]           ins_digit;
    logic                 out_free;
    logic [CRC_W-1:0]     crc_v;
    logic [DIGIT_W-1:0]   ins_xor;
    logic [BURST_W-1:0]   in_burst;

    // Bits of the final burst taken by data; a full burst counts as 128.
    assign used      = (msg_bits_reg[6:0] == 7'd0) ? 8'd128 : {1'b0, msg_bits_reg[6:0]};
    assign spill     = (used > 8'(SPILL_LIMIT));
    assign ins_digit = used[7:2];
    assign out_free  = !m_tvalid_reg || m_tready;
    assign in_burst  = {s_tdata[71:8], s_tdata[135:72]};

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb
    begin
        state_next       = state_reg;
        crc_next         = crc_reg;
        msg_bits_next    = msg_bits_reg;
        rem_next         = rem_reg;
        bursts_left_next = bursts_left_reg;
        in_message_next  = in_message_reg;
        final_next       = final_reg;
        cnt_next         = cnt_reg;
        win_next         = win_reg;
        c28_next         = c28_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tlast_next     = m_tlast_reg;
        crc_v            = crc_reg;
        ins_xor          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cnt_next = '0;
                    if (!s_tuser[0])
                    begin
                        // Length command: start over, abandoning any open message.
                        msg_bits_next    = s_tdata[7:0];
                        rem_next         = s_tdata[7:0];
                        crc_next         = CRC_INIT;
                        bursts_left_next = (s_tdata[7:0] > 8'd128) ? 2'd2 : 2'd1;
                        if (s_tdata[7:0] == 8'd0)
                        begin
                            in_message_next = 1'b0;
                            final_next      = 1'b1;
                            win_next        = '0;
                            state_next      = ST_FLUSH;
                        end
                        else
                        begin
                            in_message_next = 1'b1;
                        end
                    end
                    else if (in_message_reg)
                    begin
                        win_next         = {in_burst, {BURST_W{1'b0}}};
                        bursts_left_next = bursts_left_reg - 2'd1;
                        state_next       = ST_DATA;
                    end
                end
            end

            ST_DATA:
            begin
                // Feed the top digit into the CRC, skipping bits past the message.
                for (int j = 0; j < DIGIT_W; j++)
                begin
                    if (rem_reg > 8'(j))
                    begin
                        crc_v = crc_bit(crc_v, win_reg[WIN_W-1-j]);
                    end
                end
                crc_next = crc_v;
                rem_next = (rem_reg > 8'(DIGIT_W)) ? rem_reg - 8'(DIGIT_W) : 8'd0;
                win_next[WIN_W-1:BURST_W] = {win_reg[WIN_W-DIGIT_W-1:BURST_W],
                                             win_reg[WIN_W-1:WIN_W-DIGIT_W]};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(BURST_DIGITS - 1))
                begin
                    cnt_next = '0;
                    if (bursts_left_reg != 2'd0)
                    begin
                        final_next = 1'b0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        final_next      = 1'b1;
                        in_message_next = 1'b0;
                        state_next      = ST_FLUSH;
                    end
                end
            end

            ST_FLUSH:
            begin
                for (int j = 0; j < DIGIT_W; j++)
                begin
                    crc_v = crc_bit(crc_v, 1'b0);
                end
                crc_next = crc_v;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(FLUSH_DIGITS - 1))
                begin
                    cnt_next   = '0;
                    // Align the CRC to a digit boundary for the insert pass.
                    c28_next   = {crc_v[CRC_OUT_W-1:0], 4'b0000} >> used[1:0];
                    state_next = ST_INSERT;
                end
            end

            ST_INSERT:
            begin
                if (cnt_reg >= ins_digit)
                begin
                    ins_xor  = c28_reg[27:24];
                    c28_next = {c28_reg[23:0], 4'b0000};
                end
                win_next = {win_reg[WIN_W-DIGIT_W-1:0],
                            win_reg[WIN_W-1:WIN_W-DIGIT_W] ^ ins_xor};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(WIN_DIGITS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {win_reg[WIN_W-65:BURST_W], win_reg[WIN_W-1:WIN_W-64]};
                    m_tlast_next  = final_reg && !spill;
                    state_next    = (final_reg && spill) ? ST_EMIT_EXT : ST_IDLE;
                end
            end

            ST_EMIT_EXT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {win_reg[63:0], win_reg[127:64]};
                    m_tlast_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            crc_reg         <= CRC_INIT;
            msg_bits_reg    <= '0;
            rem_reg         <= '0;
            bursts_left_reg <= '0;
            in_message_reg  <= 1'b0;
            final_reg       <= 1'b0;
            cnt_reg         <= '0;
            win_reg         <= '0;
            c28_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
            m_tdata_reg     <= '0;
            m_tlast_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            crc_reg         <= crc_next;
            msg_bits_reg    <= msg_bits_next;
            rem_reg         <= rem_next;
            bursts_left_reg <= bursts_left_next;
            in_message_reg  <= in_message_next;
            final_reg       <= final_next;
            cnt_reg         <= cnt_next;
            win_reg         <= win_next;
            c28_reg         <= c28_next;
            m_tvalid_reg    <= m_tvalid_next;
            m_tdata_reg     <= m_tdata_next;
            m_tlast_reg     <= m_tlast_next;
        end
    end

    // All message bits are consumed before the flush starts.
    a_flush_no_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |-> (rem_reg == 8'd0))
        else $error("flush entered with message bits left");

    // The spill beat only follows a final burst whose CRC does not fit.
    a_ext_spill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_EXT) |-> (final_reg && spill))
        else $error("spill beat without spill");

    // The message is closed once the CRC is being finished.
    a_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH || state_reg == ST_INSERT) |-> !in_message_reg)
        else $error("message still open during CRC finish");

    // A burst taken inside a message starts the data pass.
    a_burst_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser[0] && in_message_reg) |=> (state_reg == ST_DATA))
        else $error("accepted burst did not start data pass");

endmodule

FILE: tb/tb_crc24c_attach_stream_unit.sv
module tb_crc24c_attach_stream_unit;
    import crc24c_pkg::*;

    // Beat kinds on s_tuser
    localparam bit REQ_LEN  = 1'b0;
    localparam bit REQ_DATA = 1'b1;

    localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // Random part: count of beats the block actually consumes
    localparam int RAND_ITEMS = 1900;
    // Sender pauses for a full drain every this many consumed beats
    localparam int DRAIN_EVERY = 400;
    // Quiet time after the last expected beat, to watch for stray beats
    localparam int TAIL_CYCLES = 250;
    // Watchdog: cycle limit for the whole run, set well above the worst case
    localparam longint unsigned CYCLE_LIMIT = 3_000_000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;   // msg_length[7:0], data_hi[71:8], data_lo[135:72]
    logic [0:0]   s_tuser = '0;   // req_type[0]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;        // out_hi[63:0], out_lo[127:64]
    logic         m_tlast;        // out_last

    crc24c_attach_stream_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // One output beat as the block should produce it
    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
        logic        last;
    } burst_t;

    // One row of the directed plan; typed rows carry a hand-written first result
    typedef struct packed {
        logic        req;
        logic [7:0]  len;
        logic [63:0] hi;
        logic [63:0] lo;
        logic        typed;
        logic [63:0] t_hi;
        logic [63:0] t_lo;
        logic        t_last;
    } plan_row_t;

    burst_t    pending_bursts[$];
    plan_row_t plan[$];

    int mismatches = 0;
    int consumed   = 0;
    bit no_idle    = 1'b0;   // when set, neither side inserts gaps

    // Shadow of the block's message state
    logic [24:0] crc_acc;
    logic [7:0]  msg_len_r;
    logic [7:0]  bits_seen;
    logic [1:0]  bursts_to_go;
    bit          msg_open;

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Hold reset from time zero, release on an edge, never assert again
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Watchdog: count cycles and give up at the limit
    initial
    begin
        longint unsigned cycles_run;
        cycles_run = 0;
        while (cycles_run < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles_run++;
        end
        $display("tb_crc24c_attach_stream_unit: done, errors");
        $finish;
    end

    task automatic flag(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(10, 60);
        return $urandom_range(1, 3);
    endfunction

    function automatic void reset_shadow();
        crc_acc      = CRC_INIT;
        msg_len_r    = '0;
        bits_seen    = '0;
        bursts_to_go = '0;
        msg_open     = 1'b0;
    endfunction

    // Shift one message bit into the 25-bit register, MSB first, reduce on bit 24
    function automatic void crc_shift(input logic b);
        crc_acc = {crc_acc[23:0], b};
        if (crc_acc[24])
            crc_acc = crc_acc ^ CRC_GEN;
    endfunction

    // Flush 24 zeros, fold the CRC in after the data bits, queue one or two bursts
    function automatic void close_message(input logic [127:0] data);
        logic [23:0]  crc24;
        logic [127:0] crc_wide;
        logic [127:0] spill;
        int           used;
        int           avail;
        int           nxt;
        for (int i = 0; i < 24; i++)
            crc_shift(1'b0);
        crc24    = crc_acc[23:0];
        crc_wide = {104'b0, crc24};
        used     = int'(msg_len_r[6:0]);
        avail    = (used == 0) ? 0 : BURST_W - used;
        msg_open     = 1'b0;
        bursts_to_go = '0;
        if (avail >= 24)
        begin
            data = data ^ (crc_wide << (avail - 24));
            pending_bursts.push_back('{data[127:64], data[63:0], 1'b1});
        end
        else
        begin
            // Not enough room: top CRC bits close this burst, the rest open a new one
            nxt   = 24 - avail;
            data  = data ^ (crc_wide >> nxt);
            spill = crc_wide << (BURST_W - nxt);
            pending_bursts.push_back('{data[127:64], data[63:0], 1'b0});
            pending_bursts.push_back('{spill[127:64], spill[63:0], 1'b1});
        end
    endfunction

    // Advance the shadow by one accepted beat; return how many bursts it queued
    function automatic int predict_bursts(input logic req, input logic [7:0] len,
                                          input logic [63:0] hi, input logic [63:0] lo);
        logic [127:0] data;
        int           before_n;
        before_n = pending_bursts.size();
        data     = {hi, lo};
        if (req == REQ_LEN)
        begin
            // A new length command drops any open message
            msg_len_r    = len;
            crc_acc      = CRC_INIT;
            bits_seen    = '0;
            bursts_to_go = (len == 0) ? 2'd0 : (len > 8'd128) ? 2'd2 : 2'd1;
            if (len == 0)
                close_message('0);
            else
                msg_open = 1'b1;
        end
        else if (msg_open)
        begin
            for (int j = 127; j >= 0; j--)
            begin
                if (bits_seen < msg_len_r)
                begin
                    crc_shift(data[j]);
                    bits_seen++;
                end
            end
            bursts_to_go = bursts_to_go - 2'd1;
            if (bursts_to_go != 0)
                pending_bursts.push_back('{hi, lo, 1'b0});
            else
                close_message(data);
        end
        return pending_bursts.size() - before_n;
    endfunction

    // Drive one beat, wait for the handshake, then predict. Called right after an edge.
    task automatic send_beat(input logic req, input logic [7:0] len,
                             input logic [63:0] hi, input logic [63:0] lo,
                             output int n_new);
        int  gap;
        bit  dropped;
        gap = (no_idle || $urandom_range(0, 9) < 6) ? 0 : idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {lo, hi, len};
        do
            @(posedge clk);
        while (!s_tready);
        dropped = (req == REQ_DATA) && !msg_open;
        n_new   = predict_bursts(req, len, hi, lo);
        if (!dropped)
            consumed++;
    endtask

    // Lower valid and wait until every queued burst has come out
    task automatic drain_output();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_bursts.size() != 0);
    endtask

    function automatic void add_row(input logic req, input logic [7:0] len,
                                    input logic [63:0] hi, input logic [63:0] lo,
                                    input logic typed, input logic [63:0] t_hi,
                                    input logic [63:0] t_lo, input logic t_last);
        plan.push_back('{req, len, hi, lo, typed, t_hi, t_lo, t_last});
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // One message with random content; now and then cut short so the next command drops it
    task automatic run_message();
        int          pick;
        int          n_bursts;
        int          n_new;
        logic [7:0]  len;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            len = 8'd0;
        else if (pick < 16)
            len = 8'd128;
        else if (pick < 28)
        begin
            // Lengths at the edge of the spill and at the ends of the range
            case ($urandom_range(0, 8))
                0: len = 8'd103;
                1: len = 8'd104;
                2: len = 8'd105;
                3: len = 8'd231;
                4: len = 8'd232;
                5: len = 8'd233;
                6: len = 8'd127;
                7: len = 8'd255;
                default: len = 8'd1;
            endcase
        end
        else
            len = 8'($urandom_range(0, 255));
        send_beat(REQ_LEN, len, rand64(), rand64(), n_new);
        n_bursts = (len == 0) ? 0 : (len > 8'd128) ? 2 : 1;
        if (n_bursts > 0 && $urandom_range(0, 99) < 8)
            n_bursts = $urandom_range(0, n_bursts - 1);
        for (int k = 0; k < n_bursts; k++)
            send_beat(REQ_DATA, 8'($urandom()), rand64(), rand64(), n_new);
    endtask

    // Compare one accepted output beat with the oldest expectation
    task automatic check_beat(input logic [127:0] d, input logic l);
        burst_t want;
        if (pending_bursts.size() == 0)
        begin
            flag($sformatf("beat with nothing expected: %h last %b", d, l));
        end
        else
        begin
            want = pending_bursts.pop_front();
            if (d[63:0] !== want.hi)
                flag($sformatf("out_hi %h, want %h", d[63:0], want.hi));
            if (d[127:64] !== want.lo)
                flag($sformatf("out_lo %h, want %h", d[127:64], want.lo));
            if (l !== want.last)
                flag($sformatf("out_last %b, want %b", l, want.last));
        end
    endtask

    // Output side: check every accepted beat, stall at random
    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                check_beat(m_tdata, m_tlast);
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 7) == 0)
                    hold = idle_len();
            end
        end
    end

    initial
    begin
        int n_new;
        int next_drain;

        reset_shadow();

        // Directed plan. Typed rows: zero-length command opens with an all-zero beat,
        // non-final bursts pass through untouched.
        add_row(REQ_DATA, 8'hA5, ONES, ONES, 1'b0, '0, '0, 1'b0);  // no message: dropped
        add_row(REQ_LEN, 8'd0, '0, '0, 1'b1, '0, '0, 1'b0);
        add_row(REQ_LEN, 8'd0, ONES, ONES, 1'b1, '0, '0, 1'b0);
        add_row(REQ_LEN, 8'd1, '0, '0, 1'b0, '0, '0, 1'b0);
        add_row(REQ_DATA, 8'h00, ONES, ONES, 1'b0, '0, '0, 1'b0);
        add_row(REQ_LEN, 8'd255, '0, '0, 1'b0, '0, '0, 1'b0);
        add_row(REQ_DATA, 8'hFF, ONES, ONES, 1'b1, ONES, ONES, 1'b0);
        add_row(REQ_DATA, 8'hFF, '0, '0, 1'b0, '0, '0, 1'b0);
        // Full burst: whole CRC lands in an extra beat
        add_row(REQ_LEN, 8'd128, '0, '0, 1'b0, '0, '0, 1'b0);
        add_row(REQ_DATA, 8'h5A, 64'h8000_0000_0000_0000, 64'h1, 1'b0, '0, '0, 1'b0);
        // Exactly 24 bits free, then one short
        add_row(REQ_LEN, 8'd104, '0, '0, 1'b0, '0, '0, 1'b0);
        add_row(REQ_DATA, 8'h33, 64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A,
                1'b0, '0, '0, 1'b0);
        add_row(REQ_LEN, 8'd105, '0, '0, 1'b0, '0, '0, 1'b0);
        add_row(REQ_DATA, 8'hCC, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                1'b0, '0, '0, 1'b0);
        // CRC entirely in the high half, then starting right at the half boundary
        add_row(REQ_LEN, 8'd40, '0, '0, 1'b0, '0, '0, 1'b0);
        add_row(REQ_DATA, 8'h0F, ONES, '0, 1'b0, '0, '0, 1'b0);
        add_row(REQ_LEN, 8'd64, '0, '0, 1'b0, '0, '0, 1'b0);
        add_row(REQ_DATA, 8'hF0, '0, ONES, 1'b0, '0, '0, 1'b0);
        // Open a two-burst message and abandon it with a new command
        add_row(REQ_LEN, 8'd200, '0, '0, 1'b0, '0, '0, 1'b0);
        add_row(REQ_DATA, 8'h11, 64'h1357_9BDF_0246_8ACE, 64'hCAFE_F00D_1234_5678,
                1'b1, 64'h1357_9BDF_0246_8ACE, 64'hCAFE_F00D_1234_5678, 1'b0);
        add_row(REQ_LEN, 8'd10, '0, '0, 1'b0, '0, '0, 1'b0);
        add_row(REQ_DATA, 8'h22, 64'hDEAD_BEEF_DEAD_BEEF, 64'hBEEF_DEAD_BEEF_DEAD,
                1'b0, '0, '0, 1'b0);
        // Second burst with exactly 24 bits free
        add_row(REQ_LEN, 8'd232, '0, '0, 1'b0, '0, '0, 1'b0);
        add_row(REQ_DATA, 8'h44, 64'h3C3C_3C3C_3C3C_3C3C, 64'hC3C3_C3C3_C3C3_C3C3,
                1'b1, 64'h3C3C_3C3C_3C3C_3C3C, 64'hC3C3_C3C3_C3C3_C3C3, 1'b0);
        add_row(REQ_DATA, 8'h88, ONES, ONES, 1'b0, '0, '0, 1'b0);

        @(posedge rst_n);
        @(posedge clk);

        foreach (plan[i])
        begin
            send_beat(plan[i].req, plan[i].len, plan[i].hi, plan[i].lo, n_new);
            // Swap the predicted first beat for the hand-written one
            if (plan[i].typed && n_new > 0)
                pending_bursts[pending_bursts.size() - n_new] =
                    '{plan[i].t_hi, plan[i].t_lo, plan[i].t_last};
        end

        // Random part: mostly well-formed messages, some stray and cut-short traffic
        consumed   = 0;
        next_drain = DRAIN_EVERY;
        while (consumed < RAND_ITEMS)
        begin
            if ($urandom_range(0, 99) < 3)
                no_idle = !no_idle;
            if (consumed >= next_drain)
            begin
                drain_output();
                next_drain += DRAIN_EVERY;
            end
            if ($urandom_range(0, 99) < 6)
                send_beat(REQ_DATA, 8'($urandom()), rand64(), rand64(), n_new);
            run_message();
        end

        // Close out: wait for every queued beat, then watch for strays
        no_idle = 1'b0;
        drain_output();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_bursts.size() != 0)
            flag($sformatf("%0d expected beats never came", pending_bursts.size()));

        if (mismatches == 0)
            $display("tb_crc24c_attach_stream_unit: done, clean");
        else
            $display("tb_crc24c_attach_stream_unit: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/crc24c_pkg.sv
hw/rtl/crc24c_attach_stream_unit.sv
tb/tb_crc24c_attach_stream_unit.sv
